[sv/lcdnw_pkg.sv]
package lcdnw_pkg;

  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned CONV_BITS  = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int unsigned DIGITS     = (CONV_BITS * 30103) / 100000 + 1;
  localparam int unsigned BCD_W      = 4 * DIGITS;
  localparam int unsigned CNT_W      = $clog2(CONV_BITS + 1);
  localparam int unsigned DCNT_W     = $clog2(DIGITS + 1);

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 8;

  localparam logic [2:0] CMD_NUMBER    = 3'd0;
  localparam logic [2:0] CMD_NUMBER_AT = 3'd1;
  localparam logic [2:0] CMD_INIT      = 3'd2;
  localparam logic [2:0] CMD_CLEAR     = 3'd3;
  localparam logic [2:0] CMD_CHAR      = 3'd4;

  localparam logic [7:0] LCD_FUNC_SET    = 8'd56;
  localparam logic [7:0] LCD_DISPLAY_ON  = 8'd12;
  localparam logic [7:0] LCD_CLR_DISPLAY = 8'd1;
  localparam logic [7:0] LCD_SET_ADDR    = 8'd128;
  localparam logic [7:0] ASCII_ZERO      = 8'h30;

  localparam logic [1:0] INIT_LAST = 2'd2;

  function automatic logic [7:0] init_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = LCD_FUNC_SET;
      2'd1:    b = LCD_DISPLAY_ON;
      default: b = LCD_CLR_DISPLAY;
    endcase
    return b;
  endfunction

endpackage

[sv/lcd_decimal_number_writer.sv]
// Character-LCD write front end. Each input item is one command and produces
// up to eleven LCD bus writes on the output channel, the final one flagged by
// out_tlast. A number command runs, after its acceptance, CONV_BITS (32) steps
// of serial binary-to-BCD conversion, shifting one value bit per cycle through
// an add-3 digit register, then a pass over the BCD digits (10), each either
// skipping a leading zero or emitting a write. The positioned form adds an
// address write before the digits. Init makes three writes, clear and write
// char one, unused codes none. A write waits while the output register is
// held by the receiver. A new item is taken once the previous item's last
// write has reached the output register.
module lcd_decimal_number_writer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // value[31:0], row[32], col[38:33], char_code[46:39], zero pad[47]
  input  logic [lcdnw_pkg::IN_DATA_W-1:0]    in_tdata,
  // cmd[2:0]
  input  logic [lcdnw_pkg::IN_USER_W-1:0]    in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // bus_byte[7:0]
  output logic [lcdnw_pkg::OUT_DATA_W-1:0]   out_tdata,
  // is_data
  output logic                               out_tuser,
  output logic                               out_tlast
);
  import lcdnw_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_ADDR,
    ST_DIGITS,
    ST_INIT,
    ST_SINGLE
  } state_t;

  state_t               state_r, state_nxt;
  logic [CONV_BITS-1:0] val_r, val_nxt;
  logic [BCD_W-1:0]     bcd_r, bcd_nxt;
  logic [BCD_W-1:0]     bcd_adj;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [DCNT_W-1:0]    dcnt_r, dcnt_nxt;
  logic                 pos_r, pos_nxt;
  logic                 started_r, started_nxt;
  logic [1:0]           idx_r, idx_nxt;
  logic [7:0]           cursor_r, cursor_nxt;
  logic [7:0]           byte_r, byte_nxt;
  logic                 isdata_r, isdata_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_byte_r, out_byte_nxt;
  logic                 out_isdata_r, out_isdata_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 slot_free;
  logic [3:0]           top_digit;

  assign slot_free  = !out_valid_r || out_tready;
  assign top_digit  = bcd_r[BCD_W-1 -: 4];
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_isdata_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3
                                                    : bcd_r[4*i +: 4];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    val_nxt        = val_r;
    bcd_nxt        = bcd_r;
    cnt_nxt        = cnt_r;
    dcnt_nxt       = dcnt_r;
    pos_nxt        = pos_r;
    started_nxt    = started_r;
    idx_nxt        = idx_r;
    cursor_nxt     = cursor_r;
    byte_nxt       = byte_r;
    isdata_nxt     = isdata_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_byte_nxt   = out_byte_r;
    out_isdata_nxt = out_isdata_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          case (in_tuser)
            CMD_NUMBER, CMD_NUMBER_AT: begin
              val_nxt   = in_tdata[CONV_BITS-1:0];
              bcd_nxt   = '0;
              cnt_nxt   = CNT_W'(CONV_BITS);
              pos_nxt   = (in_tuser == CMD_NUMBER_AT);
              state_nxt = ST_CONV;
              if (in_tuser == CMD_NUMBER_AT) begin
                cursor_nxt = {1'b0, in_tdata[32], in_tdata[38:33]};
              end
            end
            CMD_INIT: begin
              idx_nxt    = '0;
              cursor_nxt = '0;
              state_nxt  = ST_INIT;
            end
            CMD_CLEAR: begin
              byte_nxt   = LCD_CLR_DISPLAY;
              isdata_nxt = 1'b0;
              state_nxt  = ST_SINGLE;
            end
            CMD_CHAR: begin
              byte_nxt   = in_tdata[46:39];
              isdata_nxt = 1'b1;
              state_nxt  = ST_SINGLE;
            end
            default: ;
          endcase
        end
      end
      ST_CONV: begin
        bcd_nxt = {bcd_adj[BCD_W-2:0], val_r[CONV_BITS-1]};
        val_nxt = val_r << 1;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          dcnt_nxt    = DCNT_W'(DIGITS);
          started_nxt = 1'b0;
          state_nxt   = pos_r ? ST_ADDR : ST_DIGITS;
        end
      end
      ST_ADDR: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = cursor_r + LCD_SET_ADDR;
          out_isdata_nxt = 1'b0;
          out_last_nxt   = 1'b0;
          state_nxt      = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (top_digit == 4'd0 && !started_r && dcnt_r != DCNT_W'(1)) begin
          bcd_nxt  = bcd_r << 4;
          dcnt_nxt = dcnt_r - DCNT_W'(1);
        end else if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = ASCII_ZERO | {4'h0, top_digit};
          out_isdata_nxt = 1'b1;
          out_last_nxt   = (dcnt_r == DCNT_W'(1));
          cursor_nxt     = cursor_r + 8'd1;
          started_nxt    = 1'b1;
          bcd_nxt        = bcd_r << 4;
          dcnt_nxt       = dcnt_r - DCNT_W'(1);
          if (dcnt_r == DCNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_INIT: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = init_byte(idx_r);
          out_isdata_nxt = 1'b0;
          out_last_nxt   = (idx_r == INIT_LAST);
          idx_nxt        = idx_r + 2'd1;
          if (idx_r == INIT_LAST) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_SINGLE: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = byte_r;
          out_isdata_nxt = isdata_r;
          out_last_nxt   = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      dcnt_r      <= '0;
      pos_r       <= 1'b0;
      started_r   <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      dcnt_r      <= dcnt_nxt;
      pos_r       <= pos_nxt;
      started_r   <= started_nxt;
      idx_r       <= idx_nxt;
    end
    val_r        <= val_nxt;
    bcd_r        <= bcd_nxt;
    byte_r       <= byte_nxt;
    isdata_r     <= isdata_nxt;
    out_byte_r   <= out_byte_nxt;
    out_isdata_r <= out_isdata_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule
